// ===== design/blp_pkg.sv =====
// ----------------------------------------------------------------------------
// blp_pkg
// Types and constants shared by the lamp scanner and its button debouncer.
// ----------------------------------------------------------------------------
package blp_pkg;

  localparam int PatW    = 6;
  localparam int LampW   = 4;
  localparam int ModeW   = 3;
  localparam int CfgW    = 8;
  localparam int CfgIdxW = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_SAMPLES_PER_WINDOW = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_THRESHOLD    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_WINDOWS_PER_STEP   = 2'd2;

  localparam logic [CfgW-1:0] SAMPLES_RESET   = 8'd100;
  localparam logic [CfgW-1:0] THRESHOLD_RESET = 8'd70;
  localparam logic [CfgW-1:0] WINDOWS_RESET   = 8'd10;

  // Modes
  localparam logic [ModeW-1:0] MODE_PAUSE0 = 3'd0;
  localparam logic [ModeW-1:0] MODE_ONE    = 3'd1;
  localparam logic [ModeW-1:0] MODE_THREE  = 3'd3;
  localparam logic [ModeW-1:0] MODE_FIVE   = 3'd5;
  localparam logic [ModeW-1:0] MODE_LAST   = 3'd5;

  // Start patterns (also the low-end bounce points) and high-end bounce points
  localparam logic [PatW-1:0] PAT_ONE_LO   = 6'b000001;
  localparam logic [PatW-1:0] PAT_ONE_HI   = 6'b100000;
  localparam logic [PatW-1:0] PAT_THREE_LO = 6'b000011;
  localparam logic [PatW-1:0] PAT_THREE_HI = 6'b110000;
  localparam logic [PatW-1:0] PAT_FIVE_LO  = 6'b000111;
  localparam logic [PatW-1:0] PAT_FIVE_HI  = 6'b111000;

  typedef struct packed {
    logic button_down;
  } tick_t;

  typedef struct packed {
    logic [LampW-1:0] lamps;
    logic [ModeW-1:0] mode;
  } result_t;

  // Events from the debouncer for the tick being accepted
  typedef struct packed {
    logic step_start;
    logic advance;
  } deb_evt_t;

endpackage

// ===== design/blp_stream_if.sv =====
// ----------------------------------------------------------------------------
// blp_stream_if
// Valid/ready channel carrying one payload item per transaction.
// ----------------------------------------------------------------------------
interface blp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/blp_debounce.sv =====
// ----------------------------------------------------------------------------
// blp_debounce
// Window/step tick counters and counting button debouncer with config regs.
// ----------------------------------------------------------------------------
module blp_debounce (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [blp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [blp_pkg::CfgW-1:0]     cfg_data,
  input  logic                         accept,
  input  logic                         button_down,
  output blp_pkg::deb_evt_t            evt
);
  import blp_pkg::*;

  logic [CfgW-1:0] samples_per_window;
  logic [CfgW-1:0] press_threshold;
  logic [CfgW-1:0] windows_per_step;

  logic [CfgW-1:0] sample_index, sample_index_next;
  logic [CfgW-1:0] window_index, window_index_next;
  logic [CfgW-1:0] press_count, press_count_next;
  logic            released, released_next;

  logic [CfgW-1:0] count_inc;
  logic            window_end;
  logic            window_pressed;

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_per_window <= SAMPLES_RESET;
      press_threshold    <= THRESHOLD_RESET;
      windows_per_step   <= WINDOWS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SAMPLES_PER_WINDOW: samples_per_window <= cfg_data;
        CFG_PRESS_THRESHOLD:    press_threshold    <= cfg_data;
        CFG_WINDOWS_PER_STEP:   windows_per_step   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    count_inc = press_count;
    if (button_down && press_count != '1) count_inc = press_count + 1'b1;

    // 9-bit compares: a length of zero acts as one, a lowered length ends now
    window_end     = ({1'b0, sample_index} + 9'd1) >= {1'b0, samples_per_window};
    window_pressed = count_inc > press_threshold;

    sample_index_next = sample_index + 1'b1;
    window_index_next = window_index;
    press_count_next  = count_inc;
    released_next     = released;
    evt.step_start    = (sample_index == '0) && (window_index == '0);
    evt.advance       = 1'b0;

    if (window_end) begin
      sample_index_next = '0;
      press_count_next  = '0;
      if (window_pressed) begin
        released_next = 1'b0;
      end else if (!released) begin
        evt.advance   = 1'b1;
        released_next = 1'b1;
      end
      if (({1'b0, window_index} + 9'd1) >= {1'b0, windows_per_step})
        window_index_next = '0;
      else
        window_index_next = window_index + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      window_index <= '0;
      press_count  <= '0;
      released     <= 1'b1;
    end else if (accept) begin
      sample_index <= sample_index_next;
      window_index <= window_index_next;
      press_count  <= press_count_next;
      released     <= released_next;
    end
  end

endmodule

// ===== design/bouncing_led_pattern_with_debounce.sv =====
// ----------------------------------------------------------------------------
// bouncing_led_pattern_with_debounce
// Bouncing lamp scanner with a counting button debouncer, one tick per item.
// ----------------------------------------------------------------------------
// Each tick transaction carries one button sample and yields exactly one
// result (lamps, mode) in the next cycle. The block takes a tick every clock
// cycle: all counters, the debounce decision and the pattern shift are one
// short combinational pass, and the mode, pattern and lamp registers double
// as the result register, so a new tick is taken whenever the result
// register is empty or being drained in the same cycle. Config writes must
// be made while no result is pending.
module bouncing_led_pattern_with_debounce (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [blp_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [blp_pkg::CfgW-1:0]    cfg_data,
  blp_stream_if.sink                  tick,
  blp_stream_if.source                result
);
  import blp_pkg::*;

  logic             accept;
  deb_evt_t         evt;
  tick_t            tick_data;

  logic [ModeW-1:0] mode_reg, mode_next;
  logic [PatW-1:0]  pattern, pattern_next;
  logic             moving_right, moving_right_next;
  logic [LampW-1:0] lamp_reg, lamp_next;
  logic             out_valid;

  logic [PatW-1:0]  shifted;
  logic [PatW-1:0]  lo_end, hi_end;
  logic             scanning;

  assign tick_data = tick.payload;
  assign tick.ready = !out_valid || result.ready;
  assign accept = tick.valid && tick.ready;

  blp_debounce u_debounce (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .button_down (tick_data.button_down),
    .evt         (evt)
  );

  always_comb begin
    scanning = 1'b1;
    lo_end   = PAT_ONE_LO;
    hi_end   = PAT_ONE_HI;
    unique case (mode_reg)
      MODE_ONE: begin
        lo_end = PAT_ONE_LO;
        hi_end = PAT_ONE_HI;
      end
      MODE_THREE: begin
        lo_end = PAT_THREE_LO;
        hi_end = PAT_THREE_HI;
      end
      MODE_FIVE: begin
        lo_end = PAT_FIVE_LO;
        hi_end = PAT_FIVE_HI;
      end
      default: scanning = 1'b0;
    endcase

    shifted = moving_right ? (pattern >> 1) : (pattern << 1);

    pattern_next      = pattern;
    moving_right_next = moving_right;
    lamp_next         = lamp_reg;
    mode_next         = mode_reg;

    if (evt.step_start) begin
      if (scanning) begin
        pattern_next = shifted;
        if (shifted == lo_end || shifted == hi_end) moving_right_next = !moving_right;
      end
      lamp_next = pattern_next[LampW:1];
    end

    // Mode advance follows the shift within the same tick
    if (evt.advance) begin
      mode_next = (mode_reg >= MODE_LAST) ? MODE_PAUSE0 : mode_reg + 1'b1;
      unique case (mode_next)
        MODE_ONE: begin
          pattern_next      = PAT_ONE_LO;
          moving_right_next = 1'b0;
        end
        MODE_THREE: begin
          pattern_next      = PAT_THREE_LO;
          moving_right_next = 1'b0;
        end
        MODE_FIVE: begin
          pattern_next      = PAT_FIVE_LO;
          moving_right_next = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg     <= MODE_ONE;
      pattern      <= PAT_ONE_LO;
      moving_right <= 1'b0;
      lamp_reg     <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        mode_reg     <= mode_next;
        pattern      <= pattern_next;
        moving_right <= moving_right_next;
        lamp_reg     <= lamp_next;
      end
      if (accept) out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;
    end
  end

  assign result.valid         = out_valid;
  assign result.payload.lamps = lamp_reg;
  assign result.payload.mode  = mode_reg;

endmodule
